[rtl/sgm_pkg.sv]
package sgm_pkg;

  localparam int PIX_W = 8;
  localparam int FW_W  = 11;
  localparam int FH_W  = 12;
  localparam int THR_W = 12;
  localparam int CFG_W = 12;
  localparam int IDX_W = 2;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 12'd480;
  localparam logic [THR_W-1:0] THR_CLAMP        = 12'hFFF;  // -1: clamped magnitude

  localparam logic [FH_W-1:0]  ROW_MAX  = 12'd4095;
  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             is_flush;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             frame_last;
  } edge_out_t;

  // padded 3x3 window, tap 0 is top-left, row-major
  typedef struct packed {
    logic [8:0][PIX_W-1:0] taps;
    logic                  frame_last;
  } win_entry_t;

endpackage

[rtl/sgm_front.sv]
module sgm_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  sgm_pkg::pix_in_t           in_data,
  input  logic [sgm_pkg::FW_W-1:0]   frame_width,
  input  logic [sgm_pkg::FH_W-1:0]   frame_height,
  input  logic                       q_room,
  output logic                       q_push,
  output sgm_pkg::win_entry_t        q_entry
);
  import sgm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_WR   = 1'b1;

  logic                   state_r;
  logic [CW-1:0]          col_r;
  logic [FH_W-1:0]        row_r;
  logic [CW-1:0]          out_col_r;
  logic [FH_W-1:0]        out_row_r;
  logic [CW-1:0]          ic_r;
  logic [PIX_W-1:0]       pix_r;
  logic [PIX_W-1:0]       top_q;
  logic [PIX_W-1:0]       mid_q;
  logic [8:0][PIX_W-1:0]  win_r;
  logic [8:0][PIX_W-1:0]  win_nxt;
  logic [8:0][PIX_W-1:0]  pad;

  logic [PIX_W-1:0] store_a [MAX_WIDTH];
  logic [PIX_W-1:0] store_b [MAX_WIDTH];

  logic [WW-1:0]   w_eff;
  logic [FH_W-1:0] h_eff;
  logic [CW-1:0]   ic_cur;
  logic            in_acc;
  logic            emit;
  logic            row_end;
  logic            pad_top, pad_bot, pad_left, pad_right;
  logic            last;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if ({21'd0, frame_width} > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    h_eff = (frame_height == '0) ? FH_W'(1) : frame_height;
  end

  // column counter wraps if the width shrank under it
  assign ic_cur   = ({1'b0, col_r} >= w_eff) ? '0 : col_r;
  assign in_stall = (state_r != F_IDLE) || !q_room;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      top_q <= store_b[ic_cur];
      mid_q <= store_a[ic_cur];
      ic_r  <= ic_cur;
      pix_r <= (in_data.is_flush || row_r >= h_eff) ? '0 : in_data.pixel;
    end
    if (state_r == F_WR) begin
      store_b[ic_r] <= mid_q;
      store_a[ic_r] <= pix_r;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3+0] = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = top_q;
    win_nxt[5] = mid_q;
    win_nxt[8] = pix_r;
  end

  assign emit      = (row_r >= FH_W'(1) && ic_r != '0) || row_r >= FH_W'(2);
  assign row_end   = ({1'b0, ic_r} + WW'(1)) >= w_eff;
  assign pad_top   = (out_row_r == '0);
  assign pad_bot   = ({1'b0, out_row_r} + 13'd1) >= {1'b0, h_eff};
  assign pad_left  = (out_col_r == '0);
  assign pad_right = ({1'b0, out_col_r} + WW'(1)) >= w_eff;
  assign last      = pad_bot && pad_right;

  always_comb begin
    pad = win_nxt;
    if (pad_top) begin
      pad[0] = '0; pad[1] = '0; pad[2] = '0;
    end
    if (pad_bot) begin
      pad[6] = '0; pad[7] = '0; pad[8] = '0;
    end
    if (pad_left) begin
      pad[0] = '0; pad[3] = '0; pad[6] = '0;
    end
    if (pad_right) begin
      pad[2] = '0; pad[5] = '0; pad[8] = '0;
    end
  end

  assign q_push           = (state_r == F_WR) && emit;
  assign q_entry.taps       = pad;
  assign q_entry.frame_last = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      col_r     <= '0;
      row_r     <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      win_r     <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_acc) begin
            state_r <= F_WR;
          end
        end
        F_WR: begin
          state_r <= F_IDLE;
          win_r   <= win_nxt;
          if (row_end) begin
            col_r <= '0;
            if (row_r != ROW_MAX) begin
              row_r <= row_r + FH_W'(1);
            end
          end else begin
            col_r <= ic_r + CW'(1);
          end
          if (emit) begin
            if (last) begin
              // frame done: the next item starts a new frame
              col_r     <= '0;
              row_r     <= '0;
              out_col_r <= '0;
              out_row_r <= '0;
            end else if (pad_right) begin
              out_col_r <= '0;
              if (out_row_r != ROW_MAX) begin
                out_row_r <= out_row_r + FH_W'(1);
              end
            end else begin
              out_col_r <= out_col_r + CW'(1);
            end
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

[rtl/sgm_queue.sv]
module sgm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sgm_pkg::win_entry_t push_entry,
  output logic                room,
  input  logic                pop,
  output logic                empty,
  output sgm_pkg::win_entry_t head
);
  import sgm_pkg::*;

  win_entry_t        mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_AW:0]     count_r;

  assign room  = (count_r != (Q_AW+1)'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (Q_AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (Q_AW+1)'(1);
      end
    end
  end

endmodule

[rtl/sgm_back.sv]
module sgm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  sgm_pkg::win_entry_t         q_head,
  output logic                        q_pop,
  input  logic [sgm_pkg::THR_W-1:0]   edge_threshold,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sgm_pkg::edge_out_t          out_data
);
  import sgm_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SQ   = 3'd1;
  localparam logic [2:0] B_SUM  = 3'd2;
  localparam logic [2:0] B_ROOT = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]          state_r;
  logic signed [10:0]  gx_r, gy_r;
  logic                last_r;
  logic [19:0]         sqx_r, sqy_r;
  logic [21:0]         thr_sq_r;
  logic [15:0]         rem_r, res_r, bit_r;
  logic [2:0]          step_r;
  logic [PIX_W-1:0]    val_r;
  logic                out_valid_r;
  edge_out_t           out_data_r;

  logic [9:0]          xp, xn, yp, yn;
  logic signed [21:0]  gx_sq, gy_sq;
  logic [21:0]         thr_sq;
  logic [20:0]         s;
  logic [16:0]         trial;
  logic                out_free;

  always_comb begin
    xp = 10'(q_head.taps[2]) + {1'b0, q_head.taps[5], 1'b0} + 10'(q_head.taps[8]);
    xn = 10'(q_head.taps[0]) + {1'b0, q_head.taps[3], 1'b0} + 10'(q_head.taps[6]);
    yp = 10'(q_head.taps[0]) + {1'b0, q_head.taps[1], 1'b0} + 10'(q_head.taps[2]);
    yn = 10'(q_head.taps[6]) + {1'b0, q_head.taps[7], 1'b0} + 10'(q_head.taps[8]);
  end

  assign gx_sq  = gx_r * gx_r;
  assign gy_sq  = gy_r * gy_r;
  assign thr_sq = edge_threshold[10:0] * edge_threshold[10:0];
  assign s      = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign trial  = {1'b0, res_r} + {1'b0, bit_r};

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        gx_r   <= $signed({1'b0, xp}) - $signed({1'b0, xn});
        gy_r   <= $signed({1'b0, yp}) - $signed({1'b0, yn});
        last_r <= q_head.frame_last;
      end
      B_SQ: begin
        sqx_r    <= gx_sq[19:0];
        sqy_r    <= gy_sq[19:0];
        thr_sq_r <= thr_sq;
      end
      B_SUM: begin
        rem_r  <= s[15:0];
        res_r  <= '0;
        bit_r  <= 16'h4000;
        step_r <= '0;
        if (edge_threshold == THR_CLAMP) begin
          val_r <= EDGE_ON;   // saturated unless the root runs
        end else if (edge_threshold[THR_W-1]) begin
          val_r <= EDGE_ON;
        end else begin
          val_r <= ({1'b0, s} > thr_sq_r) ? EDGE_ON : EDGE_OFF;
        end
      end
      B_ROOT: begin
        // one bit of the integer square root per cycle
        if ({1'b0, rem_r} >= trial) begin
          rem_r <= rem_r - trial[15:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        step_r <= step_r + 3'd1;
      end
      B_OUT: begin
        if (out_free) begin
          out_data_r.edge_value <= val_r;
          out_data_r.frame_last <= last_r;
        end
      end
      default: ;
    endcase
    if (state_r == B_ROOT && step_r == 3'd7) begin
      val_r <= ({1'b0, rem_r} >= trial) ? PIX_W'((res_r >> 1) + bit_r) : PIX_W'(res_r >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: if (!q_empty) state_r <= B_SQ;
        B_SQ:   state_r <= B_SUM;
        B_SUM: begin
          if (edge_threshold == THR_CLAMP && s[20:16] == '0) begin
            state_r <= B_ROOT;
          end else begin
            state_r <= B_OUT;
          end
        end
        B_ROOT: if (step_r == 3'd7) state_r <= B_OUT;
        B_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/sobel_gradient_magnitude_top.sv]
// Path: an accepted item passes the front's write state, the queue and the back's states
//   B_IDLE, B_SQ, B_SUM, then B_ROOT in clamp mode unless the magnitude saturates, and B_OUT.
// Throughput: the front stalls input while it writes the line store it just read;
//   the back takes its next item only once a result has left B_OUT; the root has 8 steps.
// Reset: synchronous, active low; clears counters, window, queue and output valid and
//   loads 640 x 480, clamp mode. Line stores are not cleared.
module sobel_gradient_magnitude_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sgm_pkg::pix_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sgm_pkg::edge_out_t          out_data,
  input  logic                        cfg_we,
  input  logic [sgm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sgm_pkg::CFG_W-1:0]   cfg_wdata
);
  import sgm_pkg::*;

  logic [FW_W-1:0]  frame_width_r;
  logic [FH_W-1:0]  frame_height_r;
  logic [THR_W-1:0] edge_threshold_r;

  logic       q_push, q_pop, q_room, q_empty;
  win_entry_t q_entry, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= FRAME_WIDTH_RST;
      frame_height_r   <= FRAME_HEIGHT_RST;
      edge_threshold_r <= THR_CLAMP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:    frame_width_r    <= cfg_wdata[FW_W-1:0];
        CFG_FRAME_HEIGHT:   frame_height_r   <= cfg_wdata[FH_W-1:0];
        CFG_EDGE_THRESHOLD: edge_threshold_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  sgm_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .q_room       (q_room),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  sgm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .room       (q_room),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  sgm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .edge_threshold (edge_threshold_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule

[rtl/sgm_checker.sv]
module sgm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input sgm_pkg::edge_out_t          out_data
);

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // the front stalls input while it does the line store write after accepting an item
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted on back-to-back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // after reset, no result appears before an item could have passed through
  a_no_fast_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result appeared too soon after reset");

endmodule

bind sobel_gradient_magnitude_top sgm_checker u_sgm_checker (.*);
